// ----- hw/rtl/char_lcd_refresh_engine_defines.svh -----
// Assertion macros for the character LCD refresh engine.
// Depends on a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef CHAR_LCD_REFRESH_ENGINE_DEFINES_SVH
`define CHAR_LCD_REFRESH_ENGINE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CLRE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CLRE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CLRE_ASSERT_IMPL(label, ante, cons)
`define CLRE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hw/rtl/clre_pkg.sv -----
// Shared constants, types and the row base table of the character LCD refresh engine.
// Used by clre_ctrl, clre_dpath and char_lcd_refresh_engine; depends on nothing.
package clre_pkg;

  localparam int ROWS      = 4;
  localparam int COLS      = 20;
  localparam int NUM_CELLS = ROWS * COLS;
  localparam int ADDR_W    = $clog2(NUM_CELLS);
  localparam int ROW_W     = 2;
  localparam int COL_W     = 5;

  localparam logic [7:0] SPACE_CODE = 8'h20;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  typedef enum logic {
    PH_ADDR = 1'b0,
    PH_DATA = 1'b1
  } phase_t;

  typedef struct packed {
    logic wr_en;
    logic clr_all;
    logic emit_addr;
    logic emit_data;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
  } sts_t;

  function automatic logic [7:0] row_base(input logic [ROW_W-1:0] r);
    logic [7:0] b;
    case (r)
      2'd0:    b = 8'h80;
      2'd1:    b = 8'hC0;
      2'd2:    b = 8'h94;
      2'd3:    b = 8'hD4;
      default: b = 8'h80;
    endcase
    return b;
  endfunction

endpackage

// ----- hw/rtl/clre_ctrl.sv -----
// Controller of the refresh engine: send phase state machine, dirty flag and datapath commands.
// Depends on clre_pkg.
module clre_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [1:0]         kind,
  input  logic [2:0]         row,
  input  logic [4:0]         col,
  input  clre_pkg::sts_t     sts,
  output clre_pkg::cmd_t     cmd,
  output logic               dirty
);

  clre_pkg::phase_t state_r, state_nxt;
  logic             dirty_r, dirty_nxt;
  logic             row_ok, col_ok, tick_go;

  assign row_ok  = (row >= 3'd1) && (row <= 3'(clre_pkg::ROWS));
  assign col_ok  = (col >= 5'd1) && (col <= 5'(clre_pkg::COLS));
  assign tick_go = accept && (kind == clre_pkg::KIND_TICK) && dirty_r;
  assign dirty   = dirty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= clre_pkg::PH_ADDR;
      dirty_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      dirty_r <= dirty_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    dirty_nxt = dirty_r;
    if (accept && (kind == clre_pkg::KIND_WRITE) && row_ok) begin
      dirty_nxt = 1'b1;
    end
    if (accept && (kind == clre_pkg::KIND_CLEAR)) begin
      dirty_nxt = 1'b1;
    end
    if (tick_go) begin
      case (state_r)
        clre_pkg::PH_ADDR: begin
          state_nxt = clre_pkg::PH_DATA;
        end
        clre_pkg::PH_DATA: begin
          state_nxt = clre_pkg::PH_ADDR;
          if (sts.scan_last) begin
            dirty_nxt = 1'b0;
          end
        end
        default: begin
          state_nxt = clre_pkg::PH_ADDR;
        end
      endcase
    end
  end

  always_comb begin
    cmd.wr_en     = accept && (kind == clre_pkg::KIND_WRITE) && row_ok && col_ok;
    cmd.clr_all   = accept && (kind == clre_pkg::KIND_CLEAR);
    cmd.emit_addr = 1'b0;
    cmd.emit_data = 1'b0;
    case (state_r)
      clre_pkg::PH_ADDR: cmd.emit_addr = tick_go;
      clre_pkg::PH_DATA: cmd.emit_data = tick_go;
      default:           cmd.emit_addr = 1'b0;
    endcase
  end

endmodule

// ----- hw/rtl/clre_dpath.sv -----
// Datapath of the refresh engine: character memory with valid bits, scan position and result registers.
// Depends on clre_pkg.
module clre_dpath (
  input  logic           clk,
  input  logic           rst_n,
  input  clre_pkg::cmd_t cmd,
  input  logic [2:0]     row,
  input  logic [4:0]     col,
  input  logic [7:0]     character,
  output clre_pkg::sts_t sts,
  output logic           out_strobe,
  output logic           out_is_data,
  output logic [7:0]     out_lcd_byte
);

  logic [7:0]                     mem [clre_pkg::NUM_CELLS];
  logic [clre_pkg::NUM_CELLS-1:0] valid_r;
  logic [clre_pkg::ROW_W-1:0]     scan_row_r, scan_row_nxt;
  logic [clre_pkg::COL_W-1:0]     scan_col_r, scan_col_nxt;
  logic [clre_pkg::ADDR_W-1:0]    scan_addr, wr_addr;
  logic [clre_pkg::ROW_W-1:0]     wr_row;
  logic [clre_pkg::COL_W-1:0]     wr_col;
  logic [7:0]                     rd_data_r, addr_byte_r;
  logic                           rd_valid_r, strobe_r, is_data_r;

  assign wr_row    = clre_pkg::ROW_W'(row - 3'd1);
  assign wr_col    = col - 5'd1;
  assign wr_addr   = clre_pkg::ADDR_W'(wr_row) * clre_pkg::ADDR_W'(clre_pkg::COLS)
                   + clre_pkg::ADDR_W'(wr_col);
  assign scan_addr = clre_pkg::ADDR_W'(scan_row_r) * clre_pkg::ADDR_W'(clre_pkg::COLS)
                   + clre_pkg::ADDR_W'(scan_col_r);

  assign sts.scan_last = (scan_row_r == clre_pkg::ROW_W'(clre_pkg::ROWS - 1))
                      && (scan_col_r == clre_pkg::COL_W'(clre_pkg::COLS - 1));

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= character;
    end
    rd_data_r <= mem[scan_addr];
  end

  // An entry that has not been written since reset or the last clear reads as a space.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.clr_all) begin
      valid_r <= '0;
    end else if (cmd.wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    scan_row_nxt = scan_row_r;
    scan_col_nxt = scan_col_r;
    if (cmd.emit_data) begin
      if (scan_col_r == clre_pkg::COL_W'(clre_pkg::COLS - 1)) begin
        scan_col_nxt = '0;
        if (scan_row_r == clre_pkg::ROW_W'(clre_pkg::ROWS - 1)) begin
          scan_row_nxt = '0;
        end else begin
          scan_row_nxt = scan_row_r + 2'd1;
        end
      end else begin
        scan_col_nxt = scan_col_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_row_r <= '0;
      scan_col_r <= '0;
      strobe_r   <= 1'b0;
      is_data_r  <= 1'b0;
    end else begin
      scan_row_r <= scan_row_nxt;
      scan_col_r <= scan_col_nxt;
      strobe_r   <= cmd.emit_addr || cmd.emit_data;
      is_data_r  <= cmd.emit_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_valid_r  <= valid_r[scan_addr];
    addr_byte_r <= clre_pkg::row_base(scan_row_r) + 8'(scan_col_r);
  end

  assign out_strobe   = strobe_r;
  assign out_is_data  = is_data_r;
  assign out_lcd_byte = is_data_r ? (rd_valid_r ? rd_data_r : clre_pkg::SPACE_CODE)
                                  : addr_byte_r;

endmodule

// ----- hw/rtl/char_lcd_refresh_engine.sv -----
// Character LCD refresh engine, top level: 4x20 shadow store streamed as address and data bytes.
// A tick that produces a result shows it on the out_ ports in the cycle after the transfer.
// Throughput: one item per cycle; busy stays low, and the output register holds one result.
// Reset (rst_n low, synchronous) marks the store as all spaces, sets dirty, and starts the scan
// at row 1, column 1 in the address phase. The receiver cannot stall.
// Depends on clre_pkg, clre_ctrl, clre_dpath and char_lcd_refresh_engine_defines.svh.
`include "char_lcd_refresh_engine_defines.svh"
module char_lcd_refresh_engine (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_kind,
  input  logic [2:0] in_row,
  input  logic [4:0] in_col,
  input  logic [7:0] in_character,
  output logic       out_strobe,
  output logic       out_is_data,
  output logic [7:0] out_lcd_byte
);

  clre_pkg::cmd_t cmd;
  clre_pkg::sts_t sts;
  logic           accept;
  logic           dirty;

  // Every item is acted on in the cycle of its transfer, so the block never holds off start.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  clre_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .kind   (in_kind),
    .row    (in_row),
    .col    (in_col),
    .sts    (sts),
    .cmd    (cmd),
    .dirty  (dirty)
  );

  clre_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .row          (in_row),
    .col          (in_col),
    .character    (in_character),
    .sts          (sts),
    .out_strobe   (out_strobe),
    .out_is_data  (out_is_data),
    .out_lcd_byte (out_lcd_byte)
  );

  `CLRE_ASSERT_NEXT(a_strobe_needs_tick, !(accept && in_kind == clre_pkg::KIND_TICK), !out_strobe)
  `CLRE_ASSERT_IMPL(a_one_command, 1'b1, $onehot0({cmd.wr_en, cmd.clr_all, cmd.emit_addr, cmd.emit_data}))
  `CLRE_ASSERT_IMPL(a_emit_when_dirty, cmd.emit_addr || cmd.emit_data, dirty)
  `CLRE_ASSERT_IMPL(a_addr_byte_form, out_strobe && !out_is_data, out_lcd_byte[7])

endmodule

// ----- test/tb_char_lcd_refresh_engine.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for char_lcd_refresh_engine: writes, clears and refresh ticks are
// predicted by an in-bench copy of the shadow store. Depends on clre_pkg and the block's RTL.
module tb_char_lcd_refresh_engine;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic       is_data;
    logic [7:0] lcd_byte;
  } lcd_out_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_kind;
  logic [2:0] in_row;
  logic [4:0] in_col;
  logic [7:0] in_character;
  logic       out_strobe;
  logic       out_is_data;
  logic [7:0] out_lcd_byte;

  logic [7:0]                 shadow_text [clre_pkg::NUM_CELLS];
  logic                       model_dirty;
  clre_pkg::phase_t           model_phase;
  logic [clre_pkg::ROW_W-1:0] model_scan_row;
  logic [clre_pkg::COL_W-1:0] model_scan_col;

  lcd_out_t pending_lcd_out [$];
  lcd_out_t oldest_out;
  bit       allow_gaps;
  int       mismatch_count;
  int       results_checked;
  int       frames_sent;
  int       kind_count [4];

  char_lcd_refresh_engine u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_character (in_character),
    .out_strobe   (out_strobe),
    .out_is_data  (out_is_data),
    .out_lcd_byte (out_lcd_byte)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic logic [7:0] line_address(input logic [clre_pkg::ROW_W-1:0] r);
    logic [7:0] b;
    case (r)
      2'd0:    b = 8'h80;
      2'd1:    b = 8'hC0;
      2'd2:    b = 8'h94;
      default: b = 8'hD4;
    endcase
    return b;
  endfunction

  task automatic predict_lcd_stream(input logic [1:0] kind, input logic [2:0] row,
                                    input logic [4:0] col, input logic [7:0] ch);
    lcd_out_t nxt;
    int       i;
    case (kind)
      clre_pkg::KIND_WRITE: begin
        if (row >= 3'd1 && row <= 3'(clre_pkg::ROWS)) begin
          if (col >= 5'd1 && col <= 5'(clre_pkg::COLS))
            shadow_text[clre_pkg::ADDR_W'((row - 3'd1) * clre_pkg::COLS + col - 5'd1)] = ch;
          model_dirty = 1'b1;
        end
      end
      clre_pkg::KIND_CLEAR: begin
        for (i = 0; i < clre_pkg::NUM_CELLS; i++)
          shadow_text[clre_pkg::ADDR_W'(i)] = clre_pkg::SPACE_CODE;
        model_dirty = 1'b1;
      end
      clre_pkg::KIND_TICK: begin
        if (model_dirty) begin
          if (model_phase == clre_pkg::PH_ADDR) begin
            nxt.is_data  = 1'b0;
            nxt.lcd_byte = line_address(model_scan_row) + 8'(model_scan_col);
            model_phase  = clre_pkg::PH_DATA;
          end else begin
            nxt.is_data  = 1'b1;
            nxt.lcd_byte = shadow_text[clre_pkg::ADDR_W'(model_scan_row * clre_pkg::COLS
                                                         + model_scan_col)];
            model_phase  = clre_pkg::PH_ADDR;
            if (model_scan_col == clre_pkg::COL_W'(clre_pkg::COLS - 1)) begin
              model_scan_col = '0;
              if (model_scan_row == clre_pkg::ROW_W'(clre_pkg::ROWS - 1)) begin
                model_scan_row = '0;
                model_dirty    = 1'b0;
                frames_sent++;
              end else begin
                model_scan_row++;
              end
            end else begin
              model_scan_col++;
            end
          end
          pending_lcd_out.push_back(nxt);
        end
      end
      default: ;
    endcase
  endtask

  // Holds the item on the ports until a transfer happens, then updates the prediction.
  task automatic send_item(input logic [1:0] kind, input logic [2:0] row,
                           input logic [4:0] col, input logic [7:0] ch);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start        <= 1'b0;
      in_kind      <= 2'($urandom);
      in_row       <= 3'($urandom);
      in_col       <= 5'($urandom);
      in_character <= 8'($urandom);
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    start        <= 1'b1;
    in_kind      <= kind;
    in_row       <= row;
    in_col       <= col;
    in_character <= ch;
    do @(posedge clk); while (busy !== 1'b0);
    kind_count[kind]++;
    predict_lcd_stream(kind, row, col, ch);
  endtask

  task automatic send_random_item;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60)
      send_item(clre_pkg::KIND_TICK, 3'($urandom), 5'($urandom), 8'($urandom));
    else if (pick < 82)
      send_item(clre_pkg::KIND_WRITE, 3'($urandom_range(1, clre_pkg::ROWS)),
                5'($urandom_range(1, clre_pkg::COLS)), 8'($urandom));
    else if (pick < 86)
      send_item(clre_pkg::KIND_CLEAR, 3'($urandom), 5'($urandom), 8'($urandom));
    else if (pick < 90)
      send_item(KIND_UNUSED, 3'($urandom), 5'($urandom), 8'($urandom));
    else
      send_item(clre_pkg::KIND_WRITE, 3'($urandom), 5'($urandom), 8'($urandom));
  endtask

  task automatic wait_for_results;
    start <= 1'b0;
    do @(posedge clk); while (pending_lcd_out.size() != 0);
  endtask

  task automatic test_edge_cases;
    send_item(clre_pkg::KIND_TICK, 3'd0, 5'd0, 8'h00);
    send_item(clre_pkg::KIND_TICK, 3'd7, 5'd31, 8'hFF);
    send_item(clre_pkg::KIND_WRITE, 3'd1, 5'd1, 8'h00);
    send_item(clre_pkg::KIND_WRITE, 3'd4, 5'd20, 8'hFF);
    send_item(clre_pkg::KIND_WRITE, 3'd0, 5'd5, 8'h41);
    send_item(clre_pkg::KIND_WRITE, 3'd5, 5'd3, 8'h42);
    send_item(clre_pkg::KIND_WRITE, 3'd7, 5'd31, 8'h43);
    send_item(clre_pkg::KIND_WRITE, 3'd2, 5'd0, 8'hAA);
    send_item(clre_pkg::KIND_WRITE, 3'd3, 5'd21, 8'h55);
    send_item(clre_pkg::KIND_WRITE, 3'd3, 5'd31, 8'h5A);
    send_item(KIND_UNUSED, 3'd7, 5'd31, 8'hFF);
    send_item(KIND_UNUSED, 3'd0, 5'd0, 8'h00);
    send_item(clre_pkg::KIND_TICK, 3'd1, 5'd1, 8'h01);
    send_item(clre_pkg::KIND_CLEAR, 3'd7, 5'd31, 8'hFF);
    send_item(clre_pkg::KIND_TICK, 3'd2, 5'd2, 8'h02);
    send_item(clre_pkg::KIND_WRITE, 3'd2, 5'd10, 8'h55);
    send_item(clre_pkg::KIND_TICK, 3'd0, 5'd0, 8'h00);
    send_item(clre_pkg::KIND_TICK, 3'd4, 5'd16, 8'h80);
    send_item(clre_pkg::KIND_TICK, 3'd3, 5'd8, 8'h7F);
  endtask

  // Runs the scan to the end of a frame, then writes both corner cells and the end of row 2,
  // streams a whole frame from the first cell, and follows with ticks on a clean store.
  task automatic test_full_frames;
    while (model_dirty)
      send_item(clre_pkg::KIND_TICK, 3'($urandom), 5'($urandom), 8'($urandom));
    send_item(clre_pkg::KIND_WRITE, 3'd1, 5'd1, 8'h00);
    send_item(clre_pkg::KIND_WRITE, 3'd4, 5'd20, 8'hFF);
    send_item(clre_pkg::KIND_WRITE, 3'd2, 5'd20, 8'h7E);
    while (model_dirty)
      send_item(clre_pkg::KIND_TICK, 3'($urandom), 5'($urandom), 8'($urandom));
    repeat (4) send_item(clre_pkg::KIND_TICK, 3'($urandom), 5'($urandom), 8'($urandom));
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) send_random_item();
  endtask

  task automatic test_drain_pauses;
    repeat (3) begin
      repeat (20) send_random_item();
      wait_for_results();
    end
  endtask

  task automatic test_back_to_back(input int count);
    allow_gaps = 1'b0;
    repeat (count) send_random_item();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe !== 1'b0) begin
      if (pending_lcd_out.size() == 0) begin
        report_mismatch($sformatf("unexpected result is_data=%0b byte=%02h",
                                  out_is_data, out_lcd_byte));
      end else begin
        oldest_out = pending_lcd_out.pop_front();
        if (out_is_data !== oldest_out.is_data)
          report_mismatch($sformatf("is_data %0b, expected %0b", out_is_data,
                                    oldest_out.is_data));
        if (out_lcd_byte !== oldest_out.lcd_byte)
          report_mismatch($sformatf("lcd_byte %02h, expected %02h", out_lcd_byte,
                                    oldest_out.lcd_byte));
        results_checked++;
      end
    end
  end

  initial begin
    int i;
    int guard;
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_kind      <= '0;
    in_row       <= '0;
    in_col       <= '0;
    in_character <= '0;
    for (i = 0; i < clre_pkg::NUM_CELLS; i++)
      shadow_text[clre_pkg::ADDR_W'(i)] = clre_pkg::SPACE_CODE;
    model_dirty    = 1'b1;
    model_phase    = clre_pkg::PH_ADDR;
    model_scan_row = '0;
    model_scan_col = '0;
    allow_gaps     = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edge_cases();
    test_full_frames();
    test_random_traffic(200);
    test_drain_pauses();
    test_back_to_back(150);

    start <= 1'b0;
    guard = 0;
    while (pending_lcd_out.size() != 0 && guard < 50) begin
      @(posedge clk);
      guard++;
    end
    while (pending_lcd_out.size() != 0) begin
      oldest_out = pending_lcd_out.pop_front();
      report_mismatch($sformatf("missing result is_data=%0b byte=%02h", oldest_out.is_data,
                                oldest_out.lcd_byte));
    end
    repeat (4) @(posedge clk);

    $display("Covered %0d writes, %0d clears, %0d ticks and %0d unused-kind items.",
             kind_count[clre_pkg::KIND_WRITE], kind_count[clre_pkg::KIND_CLEAR],
             kind_count[clre_pkg::KIND_TICK], kind_count[KIND_UNUSED]);
    $display("Checked %0d output bytes across %0d completed frames; %0d mismatches.",
             results_checked, frames_sent, mismatch_count);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/clre_pkg.sv
hw/rtl/clre_ctrl.sv
hw/rtl/clre_dpath.sv
hw/rtl/char_lcd_refresh_engine.sv
test/tb_char_lcd_refresh_engine.sv
